FILE: rtl/shbe_pkg.sv
// ----------------------------------------------------------------------------
// shbe_pkg
// shared types and constants of the spherical-harmonic basis evaluator
// ----------------------------------------------------------------------------
package shbe_pkg;

  localparam int MaxBands = 6;
  localparam int FracBits = 15;
  localparam int NumCoef  = MaxBands * MaxBands;
  localparam int RShift   = 39 - FracBits;

  localparam logic signed [17:0] OutMax = 18'sd131071;
  localparam logic signed [17:0] OutMin = -18'sd131072;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [2:0]         order;
  } dir_t;

  function automatic logic signed [31:0] norm_at(input logic [5:0] k);
    logic signed [31:0] r;
    case (k)
      6'd0:  r = 32'sd4732765;
      6'd1:  r = -32'sd8197390;
      6'd2:  r = 32'sd8197390;
      6'd3:  r = -32'sd8197390;
      6'd4:  r = 32'sd18329921;
      6'd5:  r = -32'sd18329921;
      6'd6:  r = 32'sd5291392;
      6'd7:  r = -32'sd18329921;
      6'd8:  r = 32'sd9164961;
      6'd9:  r = -32'sd9899289;
      6'd10: r = 32'sd48496413;
      6'd11: r = -32'sd7667956;
      6'd12: r = 32'sd6260860;
      6'd13: r = 32'sd7667956;
      6'd14: r = 32'sd24248206;
      6'd15: r = -32'sd9899289;
      6'd16: r = 32'sd41999125;
      6'd17: r = -32'sd29697866;
      6'd18: r = 32'sd15874177;
      6'd19: r = 32'sd11224738;
      6'd20: r = 32'sd1774787;
      6'd21: r = 32'sd11224738;
      6'd22: r = 32'sd7937089;
      6'd23: r = -32'sd29697866;
      6'd24: r = 32'sd10499781;
      6'd25: r = -32'sd11012264;
      6'd26: r = 32'sd139295340;
      6'd27: r = 32'sd8208057;
      6'd28: r = 32'sd80422202;
      6'd29: r = 32'sd7599184;
      6'd30: r = 32'sd1962101;
      6'd31: r = 32'sd7599184;
      6'd32: r = 32'sd40211101;
      6'd33: r = 32'sd8208057;
      6'd34: r = 32'sd34823835;
      6'd35: r = -32'sd11012264;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/shbe_mul.sv
// ----------------------------------------------------------------------------
// shbe_mul
// registered q15 multiply, round half up
// ----------------------------------------------------------------------------
module shbe_mul import shbe_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] p_o
);
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [31:0] p_q;

  assign prod = 64'(a_i) * 64'(b_i);
  assign rnd  = (prod + 64'sd16384) >>> 15;

  always_ff @(posedge clk_i) begin
    p_q <= rnd[31:0];
  end
  assign p_o = p_q;
endmodule

FILE: rtl/shbe_front.sv
// ----------------------------------------------------------------------------
// shbe_front
// input capture and band-count check, feeds the direction queue
// ----------------------------------------------------------------------------
module shbe_front import shbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_data_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic               q_full_i,
  output logic               busy_o,
  output logic               push_o,
  output dir_t               push_data_o
);
  logic [2:0] order_q;
  logic       ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 3'd3;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  // orders outside 2..MaxBands are dropped here
  assign ok     = (order_q >= 3'd2) && (32'(order_q) <= MaxBands);
  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i && ok;
  assign push_data_o = '{x: dir_x_i, y: dir_y_i, z: dir_z_i, order: order_q};
endmodule

FILE: rtl/shbe_back.sv
// ----------------------------------------------------------------------------
// shbe_back
// term generation over a shared multiplier, then one coefficient per cycle
// ----------------------------------------------------------------------------
module shbe_back import shbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  dir_t               q_data_i,
  output logic               pop_o,
  output logic               coef_valid_o,
  output logic [5:0]         coef_index_o,
  output logic signed [17:0] coef_value_o,
  output logic               last_coef_o
);
  // term phase: 35 sequenced products, mul result lands the next cycle
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StTerm = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [5:0]  step_q, step_d;
  logic [5:0]  k_q, k_d;
  logic [5:0]  n_q, n_d;
  logic        pop;
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [31:0] t_q [NumCoef];
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, z4_q, x4_q, y4_q, x2y2_q;
  logic signed [31:0] t9_q, t15_q, xyz_q, zd_q, yz_q;
  logic signed [31:0] ma, mb, mp;
  logic [5:0]  wdst_q;
  logic        wen_q;
  logic        wen_d;
  logic [5:0]  wdst_d;
  logic signed [31:0] one, dxy, q5, s4;

  localparam logic [5:0] DXX = 6'd36, DYY = 6'd37, DZZ = 6'd38, DXY = 6'd39,
    DXZ = 6'd40, DZ4 = 6'd41, DX4 = 6'd42, DY4 = 6'd43, DX2Y2 = 6'd44,
    DT9 = 6'd45, DT15 = 6'd46, DXYZ = 6'd47, DZD = 6'd48, DYZ = 6'd49;

  shbe_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  assign one = 32'sd32768;
  assign dxy = xx_q - yy_q;
  assign q5  = 32'sd14 * zz_q - 32'sd21 * z4_q - one;
  assign s4  = x4_q - 32'sd6 * x2y2_q + y4_q;

  always_comb begin
    ma = '0; mb = '0; wdst_d = '0; wen_d = 1'b0;
    if (state_q == StTerm) begin
      wen_d = 1'b1;
      case (step_q)
        6'd0:  begin ma = x_q;  mb = x_q;  wdst_d = DXX; end
        6'd1:  begin ma = y_q;  mb = y_q;  wdst_d = DYY; end
        6'd2:  begin ma = z_q;  mb = z_q;  wdst_d = DZZ; end
        6'd3:  begin ma = x_q;  mb = y_q;  wdst_d = DXY; end
        6'd4:  begin ma = x_q;  mb = z_q;  wdst_d = DXZ; end
        6'd5:  begin ma = y_q;  mb = z_q;  wdst_d = DYZ; end
        6'd6:  begin ma = zz_q; mb = zz_q; wdst_d = DZ4; end
        6'd7:  begin ma = xx_q; mb = xx_q; wdst_d = DX4; end
        6'd8:  begin ma = yy_q; mb = yy_q; wdst_d = DY4; end
        6'd9:  begin ma = xx_q; mb = yy_q; wdst_d = DX2Y2; end
        6'd10: begin ma = y_q; mb = 32'sd3 * xx_q - yy_q; wdst_d = DT9; end
        6'd11: begin ma = x_q; mb = xx_q - 32'sd3 * yy_q; wdst_d = DT15; end
        6'd12: begin ma = xy_q; mb = z_q; wdst_d = DXYZ; end
        6'd13: begin ma = z_q; mb = dxy; wdst_d = DZD; end
        6'd14: begin ma = y_q; mb = 32'sd5 * zz_q - one; wdst_d = 6'd11; end
        6'd15: begin ma = z_q; mb = 32'sd5 * zz_q - 32'sd3 * one; wdst_d = 6'd12; end
        6'd16: begin ma = x_q; mb = one - 32'sd5 * zz_q; wdst_d = 6'd13; end
        6'd17: begin ma = xy_q; mb = dxy; wdst_d = 6'd16; end
        6'd18: begin ma = z_q; mb = t9_q; wdst_d = 6'd17; end
        6'd19: begin ma = xy_q; mb = 32'sd7 * zz_q - one; wdst_d = 6'd18; end
        6'd20: begin ma = yz_q; mb = 32'sd3 * one - 32'sd7 * zz_q; wdst_d = 6'd19; end
        6'd21: begin ma = xz_q; mb = 32'sd3 * one - 32'sd7 * zz_q; wdst_d = 6'd21; end
        6'd22: begin ma = dxy; mb = 32'sd7 * zz_q - one; wdst_d = 6'd22; end
        6'd23: begin ma = z_q; mb = t15_q; wdst_d = 6'd23; end
        6'd24: begin
          ma = y_q; mb = 32'sd5 * x4_q - 32'sd10 * x2y2_q + y4_q; wdst_d = 6'd25;
        end
        6'd25: begin ma = xyz_q; mb = dxy; wdst_d = 6'd26; end
        6'd26: begin ma = t9_q; mb = one - 32'sd9 * zz_q; wdst_d = 6'd27; end
        6'd27: begin ma = xyz_q; mb = 32'sd3 * zz_q - one; wdst_d = 6'd28; end
        6'd28: begin ma = y_q; mb = q5; wdst_d = 6'd29; end
        6'd29: begin
          ma = z_q; mb = 32'sd63 * z4_q - 32'sd70 * zz_q + 32'sd15 * one;
          wdst_d = 6'd30;
        end
        6'd30: begin ma = x_q; mb = q5; wdst_d = 6'd31; end
        6'd31: begin ma = zd_q; mb = 32'sd3 * zz_q - one; wdst_d = 6'd32; end
        6'd32: begin ma = t15_q; mb = one - 32'sd9 * zz_q; wdst_d = 6'd33; end
        6'd33: begin ma = z_q; mb = s4; wdst_d = 6'd34; end
        6'd34: begin
          ma = x_q; mb = x4_q - 32'sd10 * x2y2_q + 32'sd5 * y4_q; wdst_d = 6'd35;
        end
        default: wen_d = 1'b0;
      endcase
    end
  end

  // sequencer
  assign pop = (state_q == StIdle) && q_valid_i;
  assign pop_o = pop;

  always_comb begin
    state_d = state_q; step_d = step_q; k_d = k_q; n_d = n_q;
    case (state_q)
      StIdle: if (q_valid_i) begin
        state_d = StTerm; step_d = '0;
        n_d = 6'(q_data_i.order) * 6'(q_data_i.order);
      end
      StTerm: begin
        step_d = step_q + 6'd1;
        if (step_q == 6'd35) begin
          state_d = StEmit; k_d = '0;
        end
      end
      StEmit: begin
        k_d = k_q + 6'd1;
        if (k_q == n_q - 6'd1) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; step_q <= '0; k_q <= '0; n_q <= '0; wen_q <= 1'b0;
    end else begin
      state_q <= state_d; step_q <= step_d; k_q <= k_d; n_q <= n_d;
      wen_q <= wen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wdst_q <= wdst_d;
    if (pop) begin
      x_q <= 32'(q_data_i.x); y_q <= 32'(q_data_i.y); z_q <= 32'(q_data_i.z);
    end
    if (wen_q) begin
      case (wdst_q)
        DXX: xx_q <= mp;
        DYY: yy_q <= mp;
        DZZ: zz_q <= mp;
        DXY: xy_q <= mp;
        DXZ: xz_q <= mp;
        DZ4: z4_q <= mp;
        DX4: x4_q <= mp;
        DY4: y4_q <= mp;
        DX2Y2: x2y2_q <= mp;
        DT9: t9_q <= mp;
        DT15: t15_q <= mp;
        DXYZ: xyz_q <= mp;
        DZD: zd_q <= mp;
        DYZ: yz_q <= mp;
        default: if (wdst_q < 6'(NumCoef)) t_q[wdst_q] <= mp;
      endcase
    end
  end

  // terms that are read straight from the working registers
  logic               reg_hit;
  logic signed [31:0] reg_term;

  always_comb begin
    reg_hit = 1'b1; reg_term = '0;
    case (k_q)
      6'd0:  reg_term = one;
      6'd1:  reg_term = y_q;
      6'd2:  reg_term = z_q;
      6'd3:  reg_term = x_q;
      6'd4:  reg_term = xy_q;
      6'd5:  reg_term = yz_q;
      6'd6:  reg_term = 32'sd3 * zz_q - one;
      6'd7:  reg_term = xz_q;
      6'd8:  reg_term = dxy;
      6'd9:  reg_term = t9_q;
      6'd10: reg_term = xyz_q;
      6'd14: reg_term = zd_q;
      6'd15: reg_term = t15_q;
      6'd20: reg_term = 32'sd35 * z4_q - 32'sd30 * zz_q + 32'sd3 * one;
      6'd24: reg_term = s4;
      default: reg_hit = 1'b0;
    endcase
  end

  // emit pipe: fetch term, normalize product, then round and saturate
  logic signed [31:0] tm_q;
  logic signed [63:0] np_q;
  logic [5:0]  m_idx_q, e_idx_q, o_idx_q;
  logic        m_v_q, m_last_q, e_v_q, e_last_q, o_v_q, o_last_q;
  logic signed [17:0] o_val_q;
  logic signed [63:0] rr;

  assign rr = (np_q + (64'sd1 <<< (RShift - 1))) >>> RShift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0; e_v_q <= 1'b0; o_v_q <= 1'b0;
    end else begin
      m_v_q <= (state_q == StEmit);
      e_v_q <= m_v_q;
      o_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tm_q     <= reg_hit ? reg_term : t_q[k_q];
    m_idx_q  <= k_q;
    m_last_q <= (k_q == n_q - 6'd1);
    np_q     <= 64'(tm_q) * 64'(norm_at(m_idx_q));
    e_idx_q  <= m_idx_q;
    e_last_q <= m_last_q;
    o_idx_q  <= e_idx_q;
    o_last_q <= e_last_q;
    if (rr > 64'(OutMax)) o_val_q <= OutMax;
    else if (rr < 64'(OutMin)) o_val_q <= OutMin;
    else o_val_q <= rr[17:0];
  end

  assign coef_valid_o = o_v_q;
  assign coef_index_o = o_idx_q;
  assign coef_value_o = o_val_q;
  assign last_coef_o  = o_last_q;
endmodule

FILE: rtl/sh_basis_eval_core.sv
// ----------------------------------------------------------------------------
// sh_basis_eval_core
// real spherical-harmonic basis evaluator, up to six bands
// ----------------------------------------------------------------------------
// A transaction is one direction (Q1.15 x, y, z), taken when start_i is high
// and busy_o is low. For sh_order bands in 2..6 the block returns
// sh_order*sh_order coefficients in index order, one per cycle on
// coef_valid_o, with last_coef_o on the final one; other orders give no
// results. Results cannot be held off by the receiver. The back end first
// builds terms on one shared 32x32 multiplier, then emits one coefficient
// per cycle, so a direction occupies it through its term and emit phases;
// a two-entry queue lets the front take new directions meanwhile, and
// busy_o rises only when that queue is full.
module sh_basis_eval_core import shbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         sh_order_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  output logic               coef_valid_o,
  output logic [5:0]         coef_index_o,
  output logic signed [17:0] coef_value_o,
  output logic               last_coef_o
);
  logic push, pop;
  dir_t push_data;
  dir_t fifo_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;

  shbe_front u_front (
    .clk_i, .rst_ni, .start_i, .cfg_we_i, .cfg_data_i(sh_order_i),
    .dir_x_i, .dir_y_i, .dir_z_i, .q_full_i(cnt_q == 2'd2),
    .busy_o, .push_o(push), .push_data_o(push_data)
  );

  // two-entry direction queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= push_data;
  end

  shbe_back u_back (
    .clk_i, .rst_ni, .q_valid_i(cnt_q != 2'd0), .q_data_i(fifo_q[rd_q]),
    .pop_o(pop), .coef_valid_o, .coef_index_o, .coef_value_o, .last_coef_o
  );

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !push) else $error("push while busy");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_coef_o && coef_valid_o |=> !coef_valid_o) else $error("gap missing");
endmodule
